### design/opvd_pkg.sv
`timescale 1ns / 1ps

package opvd_pkg;

	localparam int PID_W      = 8;
	localparam int REPLY_ID_W = 11;
	localparam int BYTE_W     = 8;
	localparam int VALUE_W    = 15;
	localparam int MAG_W      = 14;
	localparam int DIGIT_W    = 6;
	localparam int BCD_W      = 4;

	localparam logic [REPLY_ID_W-1:0] REPLY_ID_OK = 11'h7E8;

	// Supported mode-01 PIDs
	localparam logic [PID_W-1:0] PID_ENGINE_LOAD = 8'h04;
	localparam logic [PID_W-1:0] PID_COOLANT     = 8'h05;
	localparam logic [PID_W-1:0] PID_STFT_B1     = 8'h06;
	localparam logic [PID_W-1:0] PID_LTFT_B1     = 8'h07;
	localparam logic [PID_W-1:0] PID_FUEL_PRESS  = 8'h0A;
	localparam logic [PID_W-1:0] PID_MAP         = 8'h0B;
	localparam logic [PID_W-1:0] PID_RPM         = 8'h0C;
	localparam logic [PID_W-1:0] PID_SPEED       = 8'h0D;
	localparam logic [PID_W-1:0] PID_TIMING      = 8'h0E;
	localparam logic [PID_W-1:0] PID_INTAKE_TEMP = 8'h0F;
	localparam logic [PID_W-1:0] PID_MAF         = 8'h10;
	localparam logic [PID_W-1:0] PID_THROTTLE    = 8'h11;

	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_PCT255,
		KIND_OFF40,
		KIND_PCT128,
		KIND_X3,
		KIND_RAW,
		KIND_RPM,
		KIND_TIMING,
		KIND_MAF
	} scale_kind_t;

	localparam int PERCENT      = 100;
	localparam int TEMP_OFFSET  = 40;
	localparam int TRIM_OFFSET  = 100;
	localparam int TIMING_OFFSET = 64;

	// x/255 = (x * 32897) >> 23, exact for x < 66052
	localparam logic [15:0] RECIP_255    = 16'd32897;
	localparam int          RECIP_255_SH = 23;
	localparam int          Q255_W       = 7;
	// y/25  = (y * 5243) >> 17, exact for y < 16384
	localparam logic [12:0] RECIP_25     = 13'd5243;
	localparam int          RECIP_25_SH  = 17;
	localparam int          Q100_W       = 10;
	// x/10  = (x * 52429) >> 19, exact for x < 43690
	localparam logic [15:0] RECIP_10     = 16'd52429;
	localparam int          RECIP_10_SH  = 19;
	localparam int          Q10_W        = 11;

	localparam logic [MAG_W-1:0] LIMIT_THOUSANDS = 14'd999;
	localparam logic [MAG_W-1:0] LIMIT_HUNDREDS  = 14'd99;
	localparam logic [MAG_W-1:0] LIMIT_TENS      = 14'd9;
	localparam logic [MAG_W-1:0] RADIX           = 14'd10;

	localparam logic [DIGIT_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [DIGIT_W-1:0] ASCII_SPACE = 6'd32;

endpackage

### design/opvd_in_if.sv
`timescale 1ns / 1ps

interface opvd_in_if import opvd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PID_W-1:0]      pid;
	logic [REPLY_ID_W-1:0] reply_id;
	logic [BYTE_W-1:0]     byte_a;
	logic [BYTE_W-1:0]     byte_b;

	modport source(output valid, output pid, output reply_id, output byte_a, output byte_b,
		input ready);
	modport sink(input valid, input pid, input reply_id, input byte_a, input byte_b,
		output ready);
endinterface

### design/opvd_out_if.sv
`timescale 1ns / 1ps

interface opvd_out_if import opvd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      valid_res;
	logic signed [VALUE_W-1:0] value;
	logic                      negative;
	logic [DIGIT_W-1:0]        digit_thousands;
	logic [DIGIT_W-1:0]        digit_hundreds;
	logic [DIGIT_W-1:0]        digit_tens;
	logic [DIGIT_W-1:0]        digit_ones;

	modport source(output valid, output valid_res, output value, output negative,
		output digit_thousands, output digit_hundreds, output digit_tens, output digit_ones,
		input ready);
	modport sink(input valid, input valid_res, input value, input negative,
		input digit_thousands, input digit_hundreds, input digit_tens, input digit_ones,
		output ready);
endinterface

### design/opvd_div10.sv
`timescale 1ns / 1ps

module opvd_div10 import opvd_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [MAG_W-1:0] num,
	output logic [MAG_W-1:0] quot,
	output logic [BCD_W-1:0] digit
);

	logic [MAG_W+15:0] prod;
	logic [Q10_W-1:0]  q;
	logic [MAG_W-1:0]  rem;
	logic [MAG_W-1:0]  quot_q;
	logic [BCD_W-1:0]  digit_q;

	always_comb begin
		prod = 30'(num) * 30'(RECIP_10);
		q    = prod[RECIP_10_SH +: Q10_W];
		rem  = num - 14'(MAG_W'(q) * RADIX);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_q  <= MAG_W'(q);
			digit_q <= rem[BCD_W-1:0];
		end
	end

	assign quot  = quot_q;
	assign digit = digit_q;

endmodule

### design/obd_pid_value_decoder.sv
`timescale 1ns / 1ps

// Mode-01 reply decoder.
// A beat on reply carries the requested PID, the 11-bit reply identifier and
// data bytes A and B. Each reply yields exactly one beat on result: valid_res,
// the scaled value (two's complement), a sign flag and four ASCII digits of
// the magnitude with leading zeros shown as spaces. Replies not from 0x7E8 or
// with an unsupported PID give valid_res 0, value 0 and four spaces.
// The path has seven register stages: PID decode, scaling, sign/magnitude,
// three divide-by-ten steps, and digit formatting into the output register.
// Throughput: one reply per cycle while result is not stalled; each stage
// holds one beat.
// Stalls: ready propagates back stage by stage, so bubbles are squeezed out
// and reply.ready drops only when every stage holds a beat and result is
// stalled. No beat is lost or repeated.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty and
// ready.
module obd_pid_value_decoder import opvd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	opvd_in_if.sink    reply,
	opvd_out_if.source result
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7 = !valid_s7 || result.ready;
	assign adv_s6 = !valid_s6 || adv_s7;
	assign adv_s5 = !valid_s5 || adv_s6;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign reply.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= reply.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
		end
	end

	// Stage 1: decode PID into a scaling kind, pre-multiply A by 100
	scale_kind_t kind_c;

	always_comb begin
		unique case (reply.pid)
			PID_ENGINE_LOAD, PID_THROTTLE: kind_c = KIND_PCT255;
			PID_COOLANT, PID_INTAKE_TEMP:  kind_c = KIND_OFF40;
			PID_STFT_B1, PID_LTFT_B1:      kind_c = KIND_PCT128;
			PID_FUEL_PRESS:                kind_c = KIND_X3;
			PID_MAP, PID_SPEED:            kind_c = KIND_RAW;
			PID_RPM:                       kind_c = KIND_RPM;
			PID_TIMING:                    kind_c = KIND_TIMING;
			PID_MAF:                       kind_c = KIND_MAF;
			default:                       kind_c = KIND_NONE;
		endcase
		if (reply.reply_id != REPLY_ID_OK) kind_c = KIND_NONE;
	end

	scale_kind_t           kind_s1;
	logic [BYTE_W-1:0]     a_s1;
	logic [2*BYTE_W-1:0]   ab_s1;
	logic [VALUE_W-1:0]    a100_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1 <= kind_c;
			a_s1    <= reply.byte_a;
			ab_s1   <= {reply.byte_a, reply.byte_b};
			a100_s1 <= VALUE_W'(reply.byte_a) * VALUE_W'(PERCENT);
		end
	end

	// Stage 2: apply the scaling
	logic [VALUE_W+15:0] p255;
	logic [26:0]         p25;
	logic [Q255_W-1:0]   q255;
	logic [Q100_W-1:0]   q100;
	logic [VALUE_W-1:0]  value_c;

	always_comb begin
		p255 = 31'(a100_s1) * 31'(RECIP_255);
		p25  = 27'(ab_s1[2*BYTE_W-1:2]) * 27'(RECIP_25);
		q255 = p255[RECIP_255_SH +: Q255_W];
		q100 = p25[RECIP_25_SH +: Q100_W];
		unique case (kind_s1)
			KIND_PCT255: value_c = VALUE_W'(q255);
			KIND_OFF40:  value_c = VALUE_W'(a_s1) - VALUE_W'(TEMP_OFFSET);
			KIND_PCT128: value_c = VALUE_W'(a100_s1[VALUE_W-1:7]) - VALUE_W'(TRIM_OFFSET);
			KIND_X3:     value_c = VALUE_W'({a_s1, 1'b0}) + VALUE_W'(a_s1);
			KIND_RAW:    value_c = VALUE_W'(a_s1);
			KIND_RPM:    value_c = VALUE_W'(ab_s1[2*BYTE_W-1:2]);
			KIND_TIMING: value_c = VALUE_W'(a_s1[BYTE_W-1:1]) - VALUE_W'(TIMING_OFFSET);
			KIND_MAF:    value_c = VALUE_W'(q100);
			default:     value_c = '0;
		endcase
	end

	logic               ok_s2;
	logic [VALUE_W-1:0] value_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ok_s2    <= (kind_s1 != KIND_NONE);
			value_s2 <= value_c;
		end
	end

	// Stage 3: sign and magnitude
	logic               ok_s3, neg_s3;
	logic [VALUE_W-1:0] value_s3;
	logic [MAG_W-1:0]   mag_s3;
	logic [VALUE_W-1:0] value_neg;

	assign value_neg = -value_s2;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ok_s3    <= ok_s2;
			neg_s3   <= value_s2[VALUE_W-1];
			value_s3 <= value_s2;
			mag_s3   <= value_s2[VALUE_W-1] ? value_neg[MAG_W-1:0] : value_s2[MAG_W-1:0];
		end
	end

	// Stages 4 to 6: peel off one decimal digit per stage
	logic [MAG_W-1:0] q1_s4, q2_s5, q3_s6;
	logic [BCD_W-1:0] d0_s4, d1_s5, d2_s6;

	opvd_div10 u_div10_s4 (.clk(clk), .adv(adv_s4), .num(mag_s3), .quot(q1_s4), .digit(d0_s4));
	opvd_div10 u_div10_s5 (.clk(clk), .adv(adv_s5), .num(q1_s4), .quot(q2_s5), .digit(d1_s5));
	opvd_div10 u_div10_s6 (.clk(clk), .adv(adv_s6), .num(q2_s5), .quot(q3_s6), .digit(d2_s6));

	logic               ok_s4, ok_s5, ok_s6;
	logic               neg_s4, neg_s5, neg_s6;
	logic [VALUE_W-1:0] value_s4, value_s5, value_s6;
	logic [MAG_W-1:0]   mag_s4, mag_s5, mag_s6;
	logic [BCD_W-1:0]   d0_s5, d0_s6, d1_s6;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			ok_s4    <= ok_s3;
			neg_s4   <= neg_s3;
			value_s4 <= value_s3;
			mag_s4   <= mag_s3;
		end
		if (adv_s5) begin
			ok_s5    <= ok_s4;
			neg_s5   <= neg_s4;
			value_s5 <= value_s4;
			mag_s5   <= mag_s4;
			d0_s5    <= d0_s4;
		end
		if (adv_s6) begin
			ok_s6    <= ok_s5;
			neg_s6   <= neg_s5;
			value_s6 <= value_s5;
			mag_s6   <= mag_s5;
			d0_s6    <= d0_s5;
			d1_s6    <= d1_s5;
		end
	end

	// Stage 7: thousands digit modulo ten, blanking, ASCII
	logic [MAG_W-1:0] q3_wrap;
	logic [BCD_W-1:0] d3;

	assign q3_wrap = (q3_s6 >= RADIX) ? q3_s6 - RADIX : q3_s6;
	assign d3      = q3_wrap[BCD_W-1:0];

	logic               ok_s7, neg_s7;
	logic [VALUE_W-1:0] value_s7;
	logic [DIGIT_W-1:0] thou_s7, hund_s7, tens_s7, ones_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			ok_s7    <= ok_s6;
			neg_s7   <= neg_s6;
			value_s7 <= value_s6;
			thou_s7  <= (mag_s6 > LIMIT_THOUSANDS) ? ASCII_ZERO + DIGIT_W'(d3) : ASCII_SPACE;
			hund_s7  <= (mag_s6 > LIMIT_HUNDREDS) ? ASCII_ZERO + DIGIT_W'(d2_s6) : ASCII_SPACE;
			tens_s7  <= (mag_s6 > LIMIT_TENS) ? ASCII_ZERO + DIGIT_W'(d1_s6) : ASCII_SPACE;
			ones_s7  <= ok_s6 ? ASCII_ZERO + DIGIT_W'(d0_s6) : ASCII_SPACE;
		end
	end

	assign result.valid           = valid_s7;
	assign result.valid_res       = ok_s7;
	assign result.value           = value_s7;
	assign result.negative        = neg_s7;
	assign result.digit_thousands = thou_s7;
	assign result.digit_hundreds  = hund_s7;
	assign result.digit_tens      = tens_s7;
	assign result.digit_ones      = ones_s7;

endmodule
